// ===== rtl/mf3_pkg.sv =====
`default_nettype none

package mf3_pkg;

   localparam int PIXEL_BITS      = 8;
   localparam int ROW_W           = 12;
   localparam int CSR_DATA_W      = 12;
   localparam int CSR_INDEX_W     = 1;
   localparam int WIN_TAPS        = 9;
   localparam int WIN_CENTER      = 4;
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_QCNT_W      = $clog2(RSP_QUEUE_DEPTH + 1);
   localparam int RSP_QPTR_W      = $clog2(RSP_QUEUE_DEPTH);

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } mf3_csr_index_type;

   typedef logic [PIXEL_BITS-1:0] mf3_pixel_type;

   typedef struct packed {
      mf3_pixel_type pixel_in;
      logic          flush;
   } mf3_req_type;

   typedef struct packed {
      mf3_pixel_type pixel_out;
      logic          end_of_frame;
   } mf3_rsp_type;

   // control that travels with an accepted word into the window stage
   typedef struct packed {
      logic active;      // word takes part (not ignored)
      logic line_write;  // pixel word: update the line store
      logic emit;        // word produces a result
      logic use_median;  // result position is interior
      logic eof;         // result is the last of the frame
   } mf3_step_type;

   // control that travels with the window into the result stage
   typedef struct packed {
      logic emit;
      logic use_median;
      logic eof;
   } mf3_stage_type;

endpackage

`default_nettype wire

// ===== rtl/median_filter_3x3.sv =====
// Streaming 3x3 median filter. Pixels of a frame enter in row-major order, one word per
// clock, and leave in the same order: interior pixels are replaced by the median of their
// 3x3 neighborhood, first/last row and column pass through. The result for position p is
// released by input pixel p+W+1; after the last pixel of a frame send W+1 flush words to
// drain, the final result carries end_of_frame. A pixel word during the drain, or a flush
// word before the frame's last pixel, is accepted and dropped. Writing either dimension
// register restarts the frame position (write only while the block is idle); values are
// clamped to 3..MAX_WIDTH columns and 3..4095 rows. Throughput is one word per clock; the
// word that releases a result is registered in the control stage, then in the window stage,
// and its result is pushed into the result queue, which raises rsp_valid. The only
// backpressure comes from the 4-entry result queue: req_stall rises once queued plus
// in-flight results fill it. The line store is a single-port-write, single-port-read RAM
// of MAX_WIDTH entries, each holding the two previous rows of one column; it has no reset
// and needs no clearing pass.
`default_nettype none

module median_filter_3x3
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel words in
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire mf3_req_type            req_data,
   // filtered words out
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output mf3_rsp_type                 rsp_data,
   // dimension registers
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                                req_accept;
   logic [COL_W-1:0]                    rd_addr;
   logic [COL_W-1:0]                    s0_col;
   mf3_pixel_type                       s0_pix;
   mf3_step_type                        s0_step;
   logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] window;
   mf3_stage_type                       s1_stage;
   mf3_pixel_type                       median;
   mf3_rsp_type                         result;
   logic [RSP_QCNT_W-1:0]               queue_count;
   logic [RSP_QCNT_W:0]                 credits_used;

   // Results in flight in the two stages are counted against the queue, so
   // the pipeline itself never has to stop.
   assign credits_used = {1'b0, queue_count}
                       + (RSP_QCNT_W+1)'(s0_step.emit)
                       + (RSP_QCNT_W+1)'(s1_stage.emit);
   assign req_stall    = (credits_used >= (RSP_QCNT_W+1)'(RSP_QUEUE_DEPTH));
   assign req_accept   = req_valid && !req_stall;

   // stage 0: position counters, line store read issued
   mf3_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rd_addr    (rd_addr),
      .s0_col     (s0_col),
      .s0_pix     (s0_pix),
      .s0_step    (s0_step)
   );

   // stage 1: line store update and 3x3 window shift
   mf3_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (rd_addr),
      .s0_col   (s0_col),
      .s0_pix   (s0_pix),
      .s0_step  (s0_step),
      .window   (window),
      .s1_stage (s1_stage)
   );

   // stage 2: median network into the result queue
   mf3_median u_median (
      .window (window),
      .median (median)
   );

   // border positions take the window center unchanged
   assign result.pixel_out    = s1_stage.use_median ? median : window[WIN_CENTER];
   assign result.end_of_frame = s1_stage.eof;

   mf3_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_stage.emit),
      .push_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .count     (queue_count)
   );

endmodule

`default_nettype wire

// ===== rtl/mf3_ctrl.sv =====
`default_nettype none

module mf3_ctrl
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_accept,
   input  wire mf3_req_type                       req_data,
   input  wire logic                              csr_write,
   input  wire logic [CSR_INDEX_W-1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0]             csr_wdata,
   output logic      [$clog2(MAX_WIDTH)-1:0]      rd_addr,
   output logic      [$clog2(MAX_WIDTH)-1:0]      s0_col,
   output mf3_pixel_type                          s0_pix,
   output mf3_step_type                           s0_step
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WIDTH_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam logic [COL_W-1:0] LAST_COL_RESET = COL_W'(WIDTH_RESET - 1);
   localparam logic [ROW_W-1:0] LAST_ROW_RESET = ROW_W'(1023);

   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             done_ff, done_in;
   mf3_step_type     step_ff, step_in;
   logic [COL_W-1:0] col_ff;
   mf3_pixel_type    pix_ff;

   logic [COL_W-1:0] cur_col;
   logic             col_last;
   logic             row_last;
   logic             active;
   logic             pix_emit;
   logic             emit;
   logic             out_col_last;
   logic             out_row_last;
   logic [10:0]      wv;
   logic [ROW_W-1:0] hv;

   always_comb begin
      cur_col      = (in_col_ff > last_col_ff) ? '0 : in_col_ff;
      col_last     = (cur_col >= last_col_ff);
      row_last     = (in_row_ff >= last_row_ff);
      active       = (req_data.flush == done_ff);
      pix_emit     = (in_row_ff >= ROW_W'(2)) ||
                     ((in_row_ff == ROW_W'(1)) && (cur_col != '0));
      emit         = active && (req_data.flush || pix_emit);
      out_col_last = (out_col_ff >= last_col_ff);
      out_row_last = (out_row_ff >= last_row_ff);
      wv           = csr_wdata[10:0];
      hv           = csr_wdata[ROW_W-1:0];
   end

   // next state of the position counters and dimension registers
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      done_in     = done_ff;

      if (req_accept && active) begin
         if (!req_data.flush) begin
            if (row_last && col_last) begin
               done_in   = 1'b1;
               in_col_in = '0;
            end else if (col_last) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = cur_col + COL_W'(1);
            end
         end else begin
            in_col_in = col_last ? '0 : cur_col + COL_W'(1);
         end
      end

      if (req_accept && emit) begin
         if (out_row_last && out_col_last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            done_in    = 1'b0;
         end else if (out_col_last) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end

      if (csr_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         done_in    = 1'b0;
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (wv < 11'd3) begin
                  last_col_in = COL_W'(2);
               end else if (32'(wv) > MAX_WIDTH) begin
                  last_col_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = COL_W'(wv - 11'd1);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               last_row_in = (hv < ROW_W'(3)) ? ROW_W'(2) : hv - ROW_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // control for the word entering the window stage
   always_comb begin
      step_in            = '0;
      step_in.active     = req_accept && active;
      step_in.line_write = req_accept && active && !req_data.flush;
      step_in.emit       = req_accept && emit;
      step_in.use_median = (out_row_ff != '0) && !out_row_last &&
                           (out_col_ff != '0) && !out_col_last;
      step_in.eof        = out_row_last && out_col_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= LAST_COL_RESET;
         last_row_ff <= LAST_ROW_RESET;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         done_ff     <= 1'b0;
         step_ff     <= '0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         done_ff     <= done_in;
         step_ff     <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         col_ff <= cur_col;
         pix_ff <= req_data.flush ? '0 : req_data.pixel_in;
      end
   end

   assign rd_addr = cur_col;
   assign s0_col  = col_ff;
   assign s0_pix  = pix_ff;
   assign s0_step = step_ff;

endmodule

`default_nettype wire

// ===== rtl/mf3_window.sv =====
`default_nettype none

module mf3_window
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]          s0_col,
   input  wire mf3_pixel_type                         s0_pix,
   input  wire mf3_step_type                          s0_step,
   output logic      [WIN_TAPS-1:0][PIXEL_BITS-1:0]   window,
   output mf3_stage_type                              s1_stage
);

   // each entry holds {pixel two rows up, pixel one row up} for a column
   logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_BITS-1:0] rd_q_ff;

   logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win_ff, win_in;
   mf3_stage_type                       stage_ff, stage_in;
   mf3_pixel_type                       top;
   mf3_pixel_type                       mid;

   assign top = rd_q_ff[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid = rd_q_ff[PIXEL_BITS-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= line_mem[rd_addr];
      end
      if (s0_step.line_write) begin
         line_mem[s0_col] <= {mid, s0_pix};
      end
   end

   always_comb begin
      win_in = win_ff;
      if (s0_step.active) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = top;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = mid;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = s0_pix;
      end
      stage_in.emit       = s0_step.emit;
      stage_in.use_median = s0_step.use_median;
      stage_in.eof        = s0_step.eof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         stage_ff <= '0;
      end else begin
         win_ff   <= win_in;
         stage_ff <= stage_in;
      end
   end

   assign window   = win_ff;
   assign s1_stage = stage_ff;

endmodule

`default_nettype wire

// ===== rtl/mf3_median.sv =====
`default_nettype none

module mf3_median
   import mf3_pkg::*;
(
   input  wire logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] window,
   output mf3_pixel_type                            median
);

   function automatic mf3_pixel_type min2(input mf3_pixel_type a, input mf3_pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic mf3_pixel_type max2(input mf3_pixel_type a, input mf3_pixel_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic mf3_pixel_type med3(input mf3_pixel_type a, input mf3_pixel_type b,
                                          input mf3_pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // sort each window column, then the median of 9 is the median of
   // (largest low, middle mid, smallest high)
   mf3_pixel_type lo [3];
   mf3_pixel_type md [3];
   mf3_pixel_type hi [3];

   for (genvar j = 0; j < 3; j++) begin : g_col
      always_comb begin
         lo[j] = min2(min2(window[j], window[j+3]), window[j+6]);
         md[j] = med3(window[j], window[j+3], window[j+6]);
         hi[j] = max2(max2(window[j], window[j+3]), window[j+6]);
      end
   end

   assign median = med3(max2(max2(lo[0], lo[1]), lo[2]),
                        med3(md[0], md[1], md[2]),
                        min2(min2(hi[0], hi[1]), hi[2]));

endmodule

`default_nettype wire

// ===== rtl/mf3_rsp_queue.sv =====
`default_nettype none

module mf3_rsp_queue
   import mf3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire mf3_rsp_type           push_data,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output mf3_rsp_type                rsp_data,
   output logic      [RSP_QCNT_W-1:0] count
);

   mf3_rsp_type              slot_ff [RSP_QUEUE_DEPTH];
   logic [RSP_QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [RSP_QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [RSP_QCNT_W-1:0]    count_ff, count_in;
   logic                     pop;

   // the upstream credit check keeps push away from a full queue
   always_comb begin
      pop       = (count_ff != '0) && !rsp_stall;
      wr_ptr_in = push ? wr_ptr_ff + RSP_QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + RSP_QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_QCNT_W'(push) - RSP_QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== rtl/mf3_checker.sv =====
`default_nettype none

module mf3_checker
   import mf3_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire mf3_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire mf3_rsp_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // a newly valid result word comes from an accepted word via the window stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 3))
      else $error("result word without a matching input word");

   // backpressure needs queued results: in-flight ones alone cannot fill the queue
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // an accepted flush word leaves the result valid known
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.flush |=> !$isunknown(rsp_valid))
      else $error("result valid unknown after flush word");

endmodule

bind median_filter_3x3 mf3_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb_median_filter_3x3.sv =====
`timescale 1ns / 1ps

module tb_median_filter_3x3;
   import mf3_pkg::*;

   localparam int MAX_COLS     = 1024;
   localparam int MAX_ROWS     = 4095;
   localparam int SETTLE       = 8;     // margin for the pipe to settle
   localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving on either side
   localparam int RANDOM_WORDS = 850;

   // how the expected result of a driven word is obtained
   typedef enum int {
      CHECK_PREDICT,  // whatever the predictor says
      CHECK_NONE,     // typed in: no result
      CHECK_RESULT    // typed in: exactly this result
   } word_check_type;

   typedef struct {
      mf3_req_type    word;
      word_check_type check;
      mf3_rsp_type    result;
   } script_row_type;

   // 3x3 frame, pixels 00 FF 00 / FF 80 FF / 00 FF 00, with stray words mixed in.
   // Only the center is interior: median of four 00, one 80, four FF is 80.
   script_row_type opening_script [18] = '{
      '{'{8'hA5, 1'b1}, CHECK_NONE,    '{8'h00, 1'b0}},  // flush before last pixel
      '{'{8'h00, 1'b0}, CHECK_NONE,    '{8'h00, 1'b0}},
      '{'{8'hFF, 1'b0}, CHECK_NONE,    '{8'h00, 1'b0}},
      '{'{8'h5A, 1'b1}, CHECK_NONE,    '{8'h00, 1'b0}},  // flush before last pixel
      '{'{8'h00, 1'b0}, CHECK_NONE,    '{8'h00, 1'b0}},
      '{'{8'hFF, 1'b0}, CHECK_NONE,    '{8'h00, 1'b0}},  // row 1 col 0: nothing yet
      '{'{8'h80, 1'b0}, CHECK_RESULT,  '{8'h00, 1'b0}},  // releases (0,0)
      '{'{8'hFF, 1'b0}, CHECK_RESULT,  '{8'hFF, 1'b0}},
      '{'{8'h00, 1'b0}, CHECK_RESULT,  '{8'h00, 1'b0}},
      '{'{8'hFF, 1'b0}, CHECK_RESULT,  '{8'hFF, 1'b0}},
      '{'{8'h00, 1'b0}, CHECK_RESULT,  '{8'h80, 1'b0}},  // last pixel, releases center
      '{'{8'h77, 1'b0}, CHECK_NONE,    '{8'h00, 1'b0}},  // pixel during drain
      '{'{8'hFF, 1'b1}, CHECK_RESULT,  '{8'hFF, 1'b0}},
      '{'{8'h00, 1'b1}, CHECK_RESULT,  '{8'h00, 1'b0}},
      '{'{8'hFF, 1'b1}, CHECK_RESULT,  '{8'hFF, 1'b0}},
      '{'{8'h00, 1'b1}, CHECK_RESULT,  '{8'h00, 1'b1}},  // last result of the frame
      '{'{8'h3C, 1'b0}, CHECK_PREDICT, '{8'h00, 1'b0}},  // next frame starts
      '{'{8'hC3, 1'b0}, CHECK_PREDICT, '{8'h00, 1'b0}}
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   mf3_req_type            req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   mf3_rsp_type            rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // filter state as the block should hold it
   logic [10:0]   flt_width  = 11'd1024;
   logic [11:0]   flt_height = 12'd1024;
   mf3_pixel_type line_rows [2][MAX_COLS] = '{default: '0};
   mf3_pixel_type window [WIN_TAPS] = '{default: '0};
   int unsigned   in_col, in_row, out_col, out_row;
   bit            draining;

   mf3_rsp_type    filtered_due [$];   // results still owed by the block, oldest first
   word_check_type word_check = CHECK_PREDICT;
   mf3_rsp_type    word_result = '0;
   int unsigned    counted_words;      // words that took part (not ignored)
   int             mismatch_count;
   int             quiet_cycles;
   int             req_idle_pct = 25;
   int             rsp_idle_pct = 87;

   median_filter_3x3 #(
      .MAX_WIDTH(MAX_COLS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // dimensions as the block uses them: clamped registers
   function automatic int unsigned cols_in_use();
      if (flt_width < 3) return 3;
      if (flt_width > MAX_COLS) return MAX_COLS;
      return 32'(flt_width);
   endfunction

   function automatic int unsigned rows_in_use();
      if (flt_height < 3) return 3;
      if (flt_height > MAX_ROWS) return MAX_ROWS;
      return 32'(flt_height);
   endfunction

   function automatic void restart_position();
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
      draining = 1'b0;
   endfunction

   // One accepted word through the filter; returns 1 when it releases a result.
   function automatic bit filter_word(input mf3_req_type w, output mf3_rsp_type r);
      int unsigned   wd, ht, c, rr;
      int            i, j;
      mf3_pixel_type pix, top, mid, t;
      mf3_pixel_type sorted [WIN_TAPS];
      bit            emit;
      r  = '0;
      wd = cols_in_use();
      ht = rows_in_use();
      // pixel while draining, or flush while filling: dropped
      if (w.flush != draining) return 1'b0;
      counted_words++;
      pix = w.flush ? '0 : w.pixel_in;
      c   = (in_col >= wd) ? 0 : in_col;
      rr  = in_row;
      top = line_rows[0][c];
      mid = line_rows[1][c];
      for (i = 0; i < 3; i++) begin
         window[3*i]   = window[3*i+1];
         window[3*i+1] = window[3*i+2];
      end
      window[2] = top;
      window[5] = mid;
      window[8] = pix;
      if (!w.flush) begin
         line_rows[0][c] = mid;
         line_rows[1][c] = pix;
         emit = (rr >= 2) || (rr == 1 && c >= 1);
         if (rr + 1 >= ht && c + 1 >= wd) begin
            draining = 1'b1;
            in_col   = 0;
         end else if (c + 1 >= wd) begin
            in_col = 0;
            in_row = rr + 1;
         end else begin
            in_col = c + 1;
         end
      end else begin
         emit   = 1'b1;
         in_col = (c + 1 >= wd) ? 0 : c + 1;
      end
      if (!emit) return 1'b0;

      sorted = window;
      for (i = 1; i < WIN_TAPS; i++) begin
         t = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > t) begin
            sorted[j+1] = sorted[j];
            j--;
         end
         sorted[j+1] = t;
      end
      if (out_row >= 1 && out_row + 1 < ht && out_col >= 1 && out_col + 1 < wd)
         r.pixel_out = sorted[WIN_CENTER];
      else
         r.pixel_out = window[WIN_CENTER];   // border passes through

      r.end_of_frame = (out_row + 1 >= ht) && (out_col + 1 >= wd);
      if (r.end_of_frame) begin
         restart_position();
      end else if (out_col + 1 >= wd) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
      return 1'b1;
   endfunction

   // Everything observed at the rising edge: register writes, accepted words in,
   // accepted results out.
   always @(posedge clock) begin
      mf3_rsp_type predicted;
      mf3_rsp_type oldest;
      bit          produced;
      bit          moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_write) begin
            if (csr_index == CSR_IMAGE_WIDTH) flt_width = csr_wdata[10:0];
            else flt_height = csr_wdata;
            restart_position();   // a write restarts the frame, line store kept
         end
         if (req_valid && !req_stall) begin
            moved    = 1'b1;
            produced = filter_word(req_data, predicted);
            case (word_check)
               CHECK_PREDICT: begin
                  if (produced) filtered_due.push_back(predicted);
               end
               CHECK_RESULT: begin
                  filtered_due.push_back(word_result);
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (filtered_due.size() == 0) begin
               $error("result with none expected: pixel_out=%0h end_of_frame=%0b",
                      rsp_data.pixel_out, rsp_data.end_of_frame);
               mismatch_count++;
            end else begin
               oldest = filtered_due.pop_front();
               if (rsp_data.pixel_out !== oldest.pixel_out) begin
                  $error("pixel_out: expected %0h, got %0h",
                         oldest.pixel_out, rsp_data.pixel_out);
                  mismatch_count++;
               end
               if (rsp_data.end_of_frame !== oldest.end_of_frame) begin
                  $error("end_of_frame: expected %0b, got %0b",
                         oldest.end_of_frame, rsp_data.end_of_frame);
                  mismatch_count++;
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Drive one word from a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input mf3_req_type w, input word_check_type chk,
                            input mf3_rsp_type res);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= w;
      word_check  = chk;
      word_result = res;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Sender holds off until every owed result is out, then lets the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (filtered_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input mf3_csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_dims(input logic [CSR_DATA_W-1:0] wv, input logic [CSR_DATA_W-1:0] hv);
      if ($urandom_range(1)) begin
         write_reg(CSR_IMAGE_WIDTH, wv);
         write_reg(CSR_IMAGE_HEIGHT, hv);
      end else begin
         write_reg(CSR_IMAGE_HEIGHT, hv);
         write_reg(CSR_IMAGE_WIDTH, wv);
      end
   endtask

   // Pixels then drain flushes, with a few stray words of the wrong kind mixed in.
   // Coarse frames use four levels only, so the median sees many ties.
   task automatic send_frame(input int unsigned pixel_count, input int unsigned flush_count);
      mf3_req_type w;
      int unsigned k;
      bit          coarse;
      coarse = 1'($urandom_range(1));
      for (k = 0; k < pixel_count; k++) begin
         if ($urandom_range(99) < 3) begin
            w.flush    = 1'b1;
            w.pixel_in = 8'($urandom);
            send_word(w, CHECK_PREDICT, '0);
         end
         w.flush    = 1'b0;
         w.pixel_in = coarse ? 8'($urandom_range(3) * 85) : 8'($urandom);
         send_word(w, CHECK_PREDICT, '0);
      end
      for (k = 0; k < flush_count; k++) begin
         if ($urandom_range(99) < 3) begin
            w.flush    = 1'b0;
            w.pixel_in = 8'($urandom);
            send_word(w, CHECK_PREDICT, '0);
         end
         w.flush    = 1'b1;
         w.pixel_in = 8'($urandom);
         send_word(w, CHECK_PREDICT, '0);
      end
   endtask

   initial begin
      int unsigned            total, cols, random_start, progress;
      int                     i, cut;
      bit                     need_restart;
      logic [CSR_DATA_W-1:0]  wv, hv;

      restart_position();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: smallest frame, both registers below range (clamp to 3x3)
      set_dims(12'd0, 12'd2);
      for (i = 0; i < $size(opening_script); i++)
         send_word(opening_script[i].word, opening_script[i].check, opening_script[i].result);

      // random frames, mostly well formed; some cut short in the pixels or the drain
      random_start = counted_words;
      need_restart = 1'b1;   // directed part left a frame open
      while (counted_words - random_start < RANDOM_WORDS) begin
         progress = counted_words - random_start;
         if (progress < RANDOM_WORDS / 3) begin
            req_idle_pct = 25;
            rsp_idle_pct = 87;
         end else if (progress < 2 * RANDOM_WORDS / 3) begin
            req_idle_pct = 87;
            rsp_idle_pct = 25;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (need_restart || $urandom_range(99) < 60) begin
            case ($urandom_range(9))
               0:       wv = 12'($urandom_range(2, 0));
               1:       wv = 12'($urandom_range(40, 11));
               default: wv = 12'($urandom_range(10, 3));
            endcase
            case ($urandom_range(9))
               0:       hv = 12'($urandom_range(2, 0));
               1:       hv = 12'($urandom_range(12, 7));
               default: hv = 12'($urandom_range(6, 3));
            endcase
            wait_idle();
            set_dims(wv, hv);
         end
         cols  = cols_in_use();
         total = cols * rows_in_use();
         cut   = ($urandom_range(99) < 12) ? $urandom_range(2, 1) : 0;
         case (cut)
            1:       send_frame($urandom_range(total - 1, 1), $urandom_range(2));
            2:       send_frame(total, $urandom_range(cols, 0));
            default: send_frame(total, cols + 1);
         endcase
         need_restart = (cut != 0);
      end

      // extremes, no idling: narrowest and tallest frame, only the first rows
      wait_idle();
      set_dims(12'd1, 12'd4095);
      send_frame(60, 0);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mf3_pkg.sv
rtl/mf3_ctrl.sv
rtl/mf3_window.sv
rtl/mf3_median.sv
rtl/mf3_rsp_queue.sv
rtl/median_filter_3x3.sv
rtl/mf3_checker.sv
bench/tb_median_filter_3x3.sv
